// File: rtl/core/kli_pkg.sv
`default_nettype none
package kli_pkg;

  // Table depth default
  localparam int MAX_KEYFRAMES_DEF = 16;

  // Field widths
  localparam int VAL_W     = 32;
  localparam int STEP_W    = 16;
  localparam int FLAG_W    = 4;
  localparam int KIND_W    = 3;
  localparam int SEG_OUT_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int LANES     = 3;
  localparam int PROD_W    = VAL_W + STEP_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TICKS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_FLAGS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_X          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_Z          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_FROM_FIRST = 3'd5;

  // Target kinds
  localparam logic [KIND_W-1:0] KIND_TRANSLATION = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ROTATION    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LIGHT       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BILLBOARD   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE        = 3'd4;

  // Input operation codes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic append;
    logic tick_begin;
    logic rd_start;
    logic rd_end;
    logic diff;
    logic mul;
    logic div_go;
    logic finish;
  } kli_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic div_done;
  } kli_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/kli_div.sv
`default_nettype none
module kli_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        go,
  input  wire logic [kli_pkg::PROD_W-1:0]  dividend,
  input  wire logic [kli_pkg::STEP_W-1:0]  divisor,
  output logic      [kli_pkg::VAL_W-1:0]   quotient,
  output logic                             done
);
  import kli_pkg::*;

  localparam int CNT_W = $clog2(VAL_W + 1);

  logic [STEP_W-1:0] rem;
  logic [VAL_W-1:0]  q_sh;
  logic [CNT_W-1:0]  cnt;
  logic              running;
  logic [STEP_W:0]   trial;
  logic              fits;

  // Trial subtract: bring in the next dividend bit
  assign trial = {rem, q_sh[VAL_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // Iterate one quotient bit a cycle; the high part is below the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (go) begin
      running <= 1'b1;
      cnt     <= CNT_W'(VAL_W);
      rem     <= dividend[PROD_W-1:VAL_W];
      q_sh    <= dividend[VAL_W-1:0];
    end else if (running) begin
      rem  <= fits ? STEP_W'(trial - {1'b0, divisor}) : trial[STEP_W-1:0];
      q_sh <= {q_sh[VAL_W-2:0], fits};
      cnt  <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        running <= 1'b0;
      end
    end
  end

  assign quotient = q_sh;
  assign done     = ~running;

endmodule
`default_nettype wire

// File: rtl/core/kli_datapath.sv
`default_nettype none
module kli_datapath #(
  parameter int MAX_KEYFRAMES = kli_pkg::MAX_KEYFRAMES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [kli_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [kli_pkg::VAL_W-1:0]          cfg_data,
  input  wire logic signed [kli_pkg::VAL_W-1:0]   key_x,
  input  wire logic signed [kli_pkg::VAL_W-1:0]   key_y,
  input  wire logic signed [kli_pkg::VAL_W-1:0]   key_z,
  input  wire kli_pkg::kli_cmd_t                  cmd,
  output kli_pkg::kli_sts_t                       sts,
  output logic [kli_pkg::KIND_W-1:0]              target_kind,
  output logic signed [kli_pkg::VAL_W-1:0]        out_x,
  output logic signed [kli_pkg::VAL_W-1:0]        out_y,
  output logic signed [kli_pkg::VAL_W-1:0]        out_z,
  output logic [kli_pkg::SEG_OUT_W-1:0]           segment_index
);
  import kli_pkg::*;

  localparam int CW = $clog2(MAX_KEYFRAMES + 1);
  localparam int AW = $clog2(MAX_KEYFRAMES);

  // Configuration
  logic [STEP_W-1:0] step_ticks;
  logic [FLAG_W-1:0] target_flags;
  logic [VAL_W-1:0]  end_v [LANES];
  logic              end_from_first;

  // Table and position
  logic [LANES*VAL_W-1:0] mem [MAX_KEYFRAMES];
  logic [LANES*VAL_W-1:0] rdata;
  logic [CW-1:0]          count;
  logic [CW-1:0]          seg;
  logic [STEP_W-1:0]      phase;

  // Arithmetic lanes
  logic [VAL_W-1:0]  start_v [LANES];
  logic [VAL_W:0]    diff_v  [LANES];
  logic [VAL_W:0]    diff_neg [LANES];
  logic [PROD_W-1:0] prod_v  [LANES];
  logic              neg_v   [LANES];
  logic [VAL_W-1:0]  quot_v  [LANES];
  logic [LANES-1:0]  lane_done;
  logic [VAL_W-1:0]  out_v   [LANES];
  logic              use_mem_end;

  logic [STEP_W-1:0]     step_eff;
  logic                  full;
  logic [CW:0]           seg_inc;
  logic                  stale;
  logic [CW:0]           seg_a;
  logic                  wrap;
  logic                  has_next;
  logic [AW-1:0]         end_addr;
  logic [AW-1:0]         raddr;
  logic [STEP_W:0]       ph_inc;
  logic                  roll;
  logic [CW+SEG_OUT_W-1:0] seg_ext;
  logic [KIND_W-1:0]     kind;

  assign step_eff = (step_ticks == '0) ? STEP_W'(1) : step_ticks;
  assign full     = (count == CW'(MAX_KEYFRAMES));

  // Position fix-up at the start of a tick: stale phase, then wrap
  assign seg_inc  = {1'b0, seg} + (CW+1)'(1);
  assign stale    = (phase >= step_eff);
  assign seg_a    = stale ? seg_inc : {1'b0, seg};
  assign wrap     = (seg_a >= {1'b0, count});

  // End keyframe address from the fixed-up segment
  assign has_next = (seg_inc < {1'b0, count});
  assign end_addr = has_next ? seg_inc[AW-1:0] : '0;
  assign raddr    = cmd.rd_start ? seg[AW-1:0] : end_addr;

  // Phase advance after the tick
  assign ph_inc   = {1'b0, phase} + (STEP_W+1)'(1);
  assign roll     = (ph_inc >= {1'b0, step_eff});

  assign seg_ext  = {SEG_OUT_W'(0), seg};

  // Lowest set flag picks the target
  always_comb begin
    if (target_flags[0])      kind = KIND_TRANSLATION;
    else if (target_flags[1]) kind = KIND_ROTATION;
    else if (target_flags[2]) kind = KIND_LIGHT;
    else if (target_flags[3]) kind = KIND_BILLBOARD;
    else                      kind = KIND_NONE;
  end

  // Negated differences for the magnitude
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      diff_neg[l] = (VAL_W+1)'(0) - diff_v[l];
    end
  end

  // Keyframe memory: one write or one read a cycle
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem[count[AW-1:0]] <= {key_z, key_y, key_x};
    end
    if (cmd.rd_start || cmd.rd_end) begin
      rdata <= mem[raddr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ticks     <= STEP_W'(1);
      target_flags   <= FLAG_W'(1);
      end_v[0]       <= '0;
      end_v[1]       <= '0;
      end_v[2]       <= '0;
      end_from_first <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_TICKS:     step_ticks     <= cfg_data[STEP_W-1:0];
        REG_TARGET_FLAGS:   target_flags   <= cfg_data[FLAG_W-1:0];
        REG_END_X:          end_v[0]       <= cfg_data;
        REG_END_Y:          end_v[1]       <= cfg_data;
        REG_END_Z:          end_v[2]       <= cfg_data;
        REG_END_FROM_FIRST: end_from_first <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Fill count and tick position
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      seg   <= '0;
      phase <= '0;
    end else begin
      if (cmd.append && !full) begin
        count <= count + CW'(1);
      end
      if (cmd.tick_begin) begin
        seg   <= wrap ? '0 : seg_a[CW-1:0];
        phase <= (stale || wrap) ? '0 : phase;
      end
      if (cmd.finish) begin
        if (roll) begin
          phase <= '0;
          seg   <= seg + CW'(1);
        end else begin
          phase <= ph_inc[STEP_W-1:0];
        end
      end
    end
  end

  // Lane datapath: capture start, subtract, multiply, combine
  always_ff @(posedge clk) begin
    if (cmd.rd_end) begin
      use_mem_end <= has_next || end_from_first;
    end
    for (int l = 0; l < LANES; l++) begin
      if (cmd.rd_end) begin
        start_v[l] <= rdata[l*VAL_W +: VAL_W];
      end
      if (cmd.diff) begin
        if (use_mem_end) begin
          diff_v[l] <= {rdata[l*VAL_W + VAL_W-1], rdata[l*VAL_W +: VAL_W]}
                       - {start_v[l][VAL_W-1], start_v[l]};
        end else begin
          diff_v[l] <= {end_v[l][VAL_W-1], end_v[l]}
                       - {start_v[l][VAL_W-1], start_v[l]};
        end
      end
      if (cmd.mul) begin
        neg_v[l]  <= diff_v[l][VAL_W];
        prod_v[l] <= PROD_W'((diff_v[l][VAL_W] ? diff_neg[l][VAL_W-1:0]
                                               : diff_v[l][VAL_W-1:0]) * phase);
      end
      if (cmd.finish) begin
        out_v[l] <= start_v[l] + (neg_v[l] ? (VAL_W'(0) - quot_v[l]) : quot_v[l]);
      end
    end
    if (cmd.finish) begin
      target_kind   <= kind;
      segment_index <= seg_ext[SEG_OUT_W-1:0];
    end
  end

  // One divider per component, run side by side
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    kli_div u_div (
      .clk      (clk),
      .rst      (rst),
      .go       (cmd.div_go),
      .dividend (prod_v[g]),
      .divisor  (step_eff),
      .quotient (quot_v[g]),
      .done     (lane_done[g])
    );
  end

  assign sts.empty    = (count == '0);
  assign sts.div_done = &lane_done;

  assign out_x = out_v[0];
  assign out_y = out_v[1];
  assign out_z = out_v[2];

endmodule
`default_nettype wire

// File: rtl/core/kli_ctrl.sv
`default_nettype none
module kli_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               operation,
  input  wire kli_pkg::kli_sts_t  sts,
  output kli_pkg::kli_cmd_t       cmd,
  output logic                    busy,
  output logic                    done
);
  import kli_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_START,
    S_RD_END,
    S_DIFF,
    S_MUL,
    S_DIV_GO,
    S_DIV
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && !busy;

  // Issue datapath commands per state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (operation == OP_APPEND) begin
            cmd.append = 1'b1;
          end else if (!sts.empty) begin
            cmd.tick_begin = 1'b1;
            state_next     = S_RD_START;
          end
        end
      end
      S_RD_START: begin
        cmd.rd_start = 1'b1;
        state_next   = S_RD_END;
      end
      S_RD_END: begin
        cmd.rd_end = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= cmd.finish;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/keyframe_linear_interpolator_top.sv
`default_nettype none
// Keyframe linear interpolator.
// Command channel: an item is taken at a clock edge with start high and
// busy low. operation 0 appends key_x/key_y/key_z to the keyframe table
// (ignored when the table is full) and gives no result; busy stays low, so
// the next word may follow in the next cycle. operation 1 advances one tick
// and interpolates start + (end - start) * phase / step_ticks per component.
// A tick on an empty table gives no result and leaves busy low.
// Result channel: done is high for exactly one cycle with target_kind,
// out_x/out_y/out_z and segment_index; the receiver cannot hold it off.
// Tick sequence: a tick reads the table, subtracts and multiplies, then runs
// the restoring dividers, one per component, one quotient bit per cycle over
// 32 bits. done rises and busy falls in the same cycle, so no new word is
// taken until a tick is through.
// Configuration: cfg_write with cfg_index and cfg_data; the user writes
// only while idle, and the block does not enforce it.
// Reset (rst, synchronous): empties the table, clears the tick position and
// loads step_ticks 1, target_flags 1, other registers 0. The table itself is
// not cleared; only written entries are ever read.
module keyframe_linear_interpolator_top #(
  parameter int MAX_KEYFRAMES = kli_pkg::MAX_KEYFRAMES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               operation,
  input  wire logic signed [kli_pkg::VAL_W-1:0]   key_x,
  input  wire logic signed [kli_pkg::VAL_W-1:0]   key_y,
  input  wire logic signed [kli_pkg::VAL_W-1:0]   key_z,
  output logic                                    done,
  output logic [kli_pkg::KIND_W-1:0]              target_kind,
  output logic signed [kli_pkg::VAL_W-1:0]        out_x,
  output logic signed [kli_pkg::VAL_W-1:0]        out_y,
  output logic signed [kli_pkg::VAL_W-1:0]        out_z,
  output logic [kli_pkg::SEG_OUT_W-1:0]           segment_index,
  input  wire logic                               cfg_write,
  input  wire logic [kli_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [kli_pkg::VAL_W-1:0]          cfg_data
);
  import kli_pkg::*;

  kli_cmd_t cmd;
  kli_sts_t sts;

  // Sequence each word
  kli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  // Table, position and arithmetic
  kli_datapath #(
    .MAX_KEYFRAMES (MAX_KEYFRAMES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .key_x         (key_x),
    .key_y         (key_y),
    .key_z         (key_z),
    .cmd           (cmd),
    .sts           (sts),
    .target_kind   (target_kind),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .segment_index (segment_index)
  );

endmodule
`default_nettype wire

// File: test/keyframe_linear_interpolator_top_tb.sv
`default_nettype none
module keyframe_linear_interpolator_top_tb;

  localparam int DEPTH = kli_pkg::MAX_KEYFRAMES_DEF;
  localparam int ITEMS = 1450;
  localparam int LIMIT = 600000;
  localparam int SETTLE_CYCLES = 45;
  localparam int MAX_REPORTS = 10;

  // Index codes past the last register: writes there must change nothing
  localparam logic [kli_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [kli_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [kli_pkg::KIND_W-1:0]     kind;
    logic signed [31:0]             x;
    logic signed [31:0]             y;
    logic signed [31:0]             z;
    logic [kli_pkg::SEG_OUT_W-1:0]  seg;
  } sample_t;

  // Predicts interpolated samples and holds the ones still due
  class keyframe_predictor;
    logic signed [31:0] key_x [DEPTH];
    logic signed [31:0] key_y [DEPTH];
    logic signed [31:0] key_z [DEPTH];
    logic [4:0]         key_count;
    logic [4:0]         seg_pos;
    logic [15:0]        phase;
    logic [15:0]        step_ticks;
    logic [3:0]         flags;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic               end_from_first;
    sample_t            expected_samples [$];
    int                 errors;

    function new();
      key_count = '0;
      seg_pos = '0;
      phase = '0;
      step_ticks = 16'd1;
      flags = 4'd1;
      end_x = '0;
      end_y = '0;
      end_z = '0;
      end_from_first = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [kli_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        kli_pkg::REG_STEP_TICKS:     step_ticks = data[15:0];
        kli_pkg::REG_TARGET_FLAGS:   flags = data[3:0];
        kli_pkg::REG_END_X:          end_x = data;
        kli_pkg::REG_END_Y:          end_y = data;
        kli_pkg::REG_END_Z:          end_z = data;
        kli_pkg::REG_END_FROM_FIRST: end_from_first = data[0];
        default: ;
      endcase
    endfunction

    // start + (end - start) * phase / step, quotient truncated toward zero
    function logic signed [31:0] blend(logic signed [31:0] s, logic signed [31:0] e,
                                       logic [15:0] ph, logic [15:0] st);
      longint ls, le, lph, lst, prod;
      ls = s;
      le = e;
      lph = ph;
      lst = st;
      prod = (le - ls) * lph;
      return 32'(ls + prod / lst);
    endfunction

    function void note_word(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic [15:0]        st;
      logic [4:0]         nxt;
      logic [3:0]         seg;
      logic signed [31:0] ex, ey, ez;
      sample_t            s;
      if (op == kli_pkg::OP_APPEND) begin
        // Drop appends to a full table
        if (key_count < DEPTH) begin
          key_x[key_count[3:0]] = x;
          key_y[key_count[3:0]] = y;
          key_z[key_count[3:0]] = z;
          key_count = key_count + 5'd1;
        end
      end else if (key_count != 0) begin
        st = (step_ticks == 16'd0) ? 16'd1 : step_ticks;
        // Advance past a phase left stale by a lowered step, then wrap
        if (phase >= st) begin
          seg_pos = seg_pos + 5'd1;
          phase = '0;
        end
        if (seg_pos >= key_count) begin
          seg_pos = '0;
          phase = '0;
        end
        seg = seg_pos[3:0];
        nxt = seg_pos + 5'd1;
        if (nxt < key_count) begin
          ex = key_x[nxt[3:0]];
          ey = key_y[nxt[3:0]];
          ez = key_z[nxt[3:0]];
        end else if (end_from_first) begin
          ex = key_x[0];
          ey = key_y[0];
          ez = key_z[0];
        end else begin
          ex = end_x;
          ey = end_y;
          ez = end_z;
        end
        s.x = blend(key_x[seg], ex, phase, st);
        s.y = blend(key_y[seg], ey, phase, st);
        s.z = blend(key_z[seg], ez, phase, st);
        s.seg = seg;
        phase = phase + 16'd1;
        if (phase >= st) begin
          phase = '0;
          seg_pos = seg_pos + 5'd1;
        end
        if (flags[0])      s.kind = kli_pkg::KIND_TRANSLATION;
        else if (flags[1]) s.kind = kli_pkg::KIND_ROTATION;
        else if (flags[2]) s.kind = kli_pkg::KIND_LIGHT;
        else if (flags[3]) s.kind = kli_pkg::KIND_BILLBOARD;
        else               s.kind = kli_pkg::KIND_NONE;
        expected_samples = {expected_samples, s};
      end
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: kind %0d x %h y %h z %h seg %0d",
                   got.kind, got.x, got.y, got.z, got.seg);
      end else begin
        want = expected_samples.pop_front();
        if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
            got.z !== want.z || got.seg !== want.seg) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("mismatch: expected kind %0d x %h y %h z %h seg %0d",
                     want.kind, want.x, want.y, want.z, want.seg);
            $display("          actual   kind %0d x %h y %h z %h seg %0d",
                     got.kind, got.x, got.y, got.z, got.seg);
          end
        end
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        operation = kli_pkg::OP_APPEND;
  logic [31:0] key_x = '0;
  logic [31:0] key_y = '0;
  logic [31:0] key_z = '0;
  logic        cfg_write = 1'b0;
  logic [kli_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        busy;
  logic        done;
  logic [kli_pkg::KIND_W-1:0]    target_kind;
  logic signed [31:0]            out_x;
  logic signed [31:0]            out_y;
  logic signed [31:0]            out_z;
  logic [kli_pkg::SEG_OUT_W-1:0] segment_index;

  keyframe_predictor sb;
  int   words_sent = 0;
  logic no_idle = 1'b0;
  int   cycle_count;

  keyframe_linear_interpolator_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .key_x         (key_x),
    .key_y         (key_y),
    .key_z         (key_z),
    .done          (done),
    .target_kind   (target_kind),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .segment_index (segment_index),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    for (cycle_count = 0; cycle_count < LIMIT; cycle_count++) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Check every strobed result
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_sample('{target_kind, out_x, out_y, out_z, segment_index});
  end

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Upper bits beyond each register's width are left random
  function automatic logic [31:0] draw_reg_data(logic [kli_pkg::CFG_IDX_W-1:0] idx);
    logic [31:0] data;
    data = $urandom;
    case (idx)
      kli_pkg::REG_STEP_TICKS: begin
        case ($urandom_range(0, 7))
          0:       data[15:0] = 16'd0;
          1:       data[15:0] = 16'd1;
          2:       data[15:0] = 16'hFFFF;
          3:       data[15:0] = 16'd2;
          default: data[15:0] = 16'($urandom_range(2, 24));
        endcase
      end
      kli_pkg::REG_END_X, kli_pkg::REG_END_Y, kli_pkg::REG_END_Z: data = draw_value();
      default: ;
    endcase
    return data;
  endfunction

  // Hold the word until it is taken, after a random wait unless no_idle is set
  task automatic send_word(input logic op, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    key_x <= x;
    key_y <= y;
    key_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(op, x, y, z);
  endtask

  task automatic send_tick();
    send_word(kli_pkg::OP_TICK, $urandom, $urandom, $urandom);
  endtask

  task automatic write_reg(input logic [kli_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Drop start, drain all due results, then let the block go idle
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Tick on an empty table, then a single keyframe toward the end point, then two more appends
    send_tick();
    send_word(kli_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_tick();
    send_word(kli_pkg::OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(kli_pkg::OP_APPEND, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);

    // Full-range swings over a short step, no target flag, then wrap
    settle();
    write_reg(kli_pkg::REG_STEP_TICKS, 32'd3);
    write_reg(kli_pkg::REG_TARGET_FLAGS, 32'd0);
    write_reg(kli_pkg::REG_END_X, 32'h7FFF_FFFF);
    write_reg(kli_pkg::REG_END_Y, 32'h8000_0000);
    write_reg(kli_pkg::REG_END_Z, 32'h1234_5678);
    write_reg(kli_pkg::REG_END_FROM_FIRST, 32'd0);
    repeat (7) send_tick();

    // Lowered step leaves a stale phase; close the loop on keyframe 0
    settle();
    write_reg(kli_pkg::REG_TARGET_FLAGS, 32'd8);
    write_reg(kli_pkg::REG_STEP_TICKS, 32'd1);
    write_reg(kli_pkg::REG_END_FROM_FIRST, 32'd1);
    repeat (2) send_tick();

    // Zero step acts as one
    settle();
    write_reg(kli_pkg::REG_TARGET_FLAGS, 32'd12);
    write_reg(kli_pkg::REG_STEP_TICKS, 32'd0);
    repeat (2) send_tick();

    // Longest step
    settle();
    write_reg(kli_pkg::REG_TARGET_FLAGS, 32'd2);
    write_reg(kli_pkg::REG_STEP_TICKS, 32'hFFFF);
    repeat (2) send_tick();

    // Random phases: fresh settings, then ticks mixed with appends
    while (words_sent < ITEMS) begin
      settle();
      for (int r = 0; r < 8; r++) begin
        if ($urandom_range(0, 1) == 1)
          write_reg(3'(r), draw_reg_data(3'(r)));
      end
      if ($urandom_range(0, 9) == 0)
        write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
      no_idle = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 80);
      repeat (n) begin
        if (sb.key_count < DEPTH && $urandom_range(0, 2) == 0) begin
          send_word(kli_pkg::OP_APPEND, draw_value(), draw_value(), draw_value());
          words_sent++;
        end else if (sb.key_count == DEPTH && $urandom_range(0, 19) == 0) begin
          // Append to a full table: ignored
          send_word(kli_pkg::OP_APPEND, $urandom, $urandom, $urandom);
        end else begin
          send_tick();
          words_sent++;
        end
      end
    end

    settle();
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

// File: keyframe_linear_interpolator_top.f
rtl/core/kli_pkg.sv
rtl/core/kli_div.sv
rtl/core/kli_datapath.sv
rtl/core/kli_ctrl.sv
rtl/core/keyframe_linear_interpolator_top.sv
test/keyframe_linear_interpolator_top_tb.sv
